// ===== rtl/core/ckbb_pkg.sv =====
`timescale 1ns / 1ps

package ckbb_pkg;

    // Field widths
    localparam int RGB_W   = 8;
    localparam int DIM_W   = 13;
    localparam int SCALE_W = 25;
    localparam int OUT_W   = 16;
    localparam int KEY_W   = 2;

    localparam int NUM_KEYS        = 4;
    localparam int MAX_DIM_DEFAULT = 4096;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE_X      = 2'd2;
    localparam logic [1:0] REG_SCALE_Y      = 2'd3;

    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [SCALE_W-1:0] SCALE_RST        = 25'd65536;

    // Colour keys
    localparam logic [KEY_W-1:0] KEY_ORANGE = 2'd0;
    localparam logic [KEY_W-1:0] KEY_CYAN   = 2'd1;
    localparam logic [KEY_W-1:0] KEY_LIME   = 2'd2;
    localparam logic [KEY_W-1:0] KEY_PURPLE = 2'd3;

    // Classification thresholds
    localparam logic [RGB_W-1:0] LVL_HIGH     = 8'd200;
    localparam logic [RGB_W-1:0] LVL_LOW      = 8'd50;
    localparam logic [RGB_W-1:0] LVL_MID_LOW  = 8'd80;
    localparam logic [RGB_W-1:0] LVL_MID_HIGH = 8'd180;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] key;
    } t_class;

    // First matching key wins.
    function automatic t_class classify(input logic [RGB_W-1:0] r,
                                        input logic [RGB_W-1:0] g,
                                        input logic [RGB_W-1:0] b);
        t_class c;
        logic   r_mid;
        r_mid = (r > LVL_MID_LOW) && (r < LVL_MID_HIGH);
        c.hit = 1'b1;
        if ((r > LVL_HIGH) && (g > LVL_MID_LOW) && (g < LVL_MID_HIGH) && (b < LVL_LOW)) begin
            c.key = KEY_ORANGE;
        end else if ((r < LVL_LOW) && (g > LVL_HIGH) && (b > LVL_HIGH)) begin
            c.key = KEY_CYAN;
        end else if (r_mid && (g > LVL_HIGH) && (b < LVL_LOW)) begin
            c.key = KEY_LIME;
        end else if (r_mid && (g < LVL_LOW) && (b > LVL_HIGH)) begin
            c.key = KEY_PURPLE;
        end else begin
            c.hit = 1'b0;
            c.key = KEY_ORANGE;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/ckbb_if.sv =====
`timescale 1ns / 1ps

// Pixel channel: one item is one RGB pixel with its end-of-frame flag.
interface ckbb_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [ckbb_pkg::RGB_W-1:0] red;
    logic [ckbb_pkg::RGB_W-1:0] green;
    logic [ckbb_pkg::RGB_W-1:0] blue;
    logic                       frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

// Box channel: one item is the rectangle of one colour key.
interface ckbb_box_if;
    logic                       valid;
    logic                       ready;
    logic [ckbb_pkg::KEY_W-1:0] key_index;
    logic                       seen;
    logic [ckbb_pkg::OUT_W-1:0] box_x;
    logic [ckbb_pkg::OUT_W-1:0] box_y;
    logic [ckbb_pkg::OUT_W-1:0] box_width;
    logic [ckbb_pkg::OUT_W-1:0] box_height;
    logic                       last_key;

    modport source (output valid, key_index, seen, box_x, box_y, box_width, box_height,
                    last_key, input ready);
    modport sink   (input valid, key_index, seen, box_x, box_y, box_width, box_height,
                    last_key, output ready);
endinterface

// ===== rtl/core/color_key_bounding_boxes_top.sv =====
`timescale 1ns / 1ps

// Colour-key bounding boxes. Pixels arrive in raster order on i_pixel, one per clock, and
// the block keeps its own column and row count from the image_width and image_height
// registers. Each pixel is classified into orange, cyan, lime or purple (first match wins)
// and the least and most column and row of every key are tracked. The pixel flagged
// frame_end is counted and then closes the frame: the four key records are copied into a
// snapshot buffer, tracking is cleared and the counters restart at zero, and four items
// leave on o_box in key order, the fourth with last_key set. Each rectangle is scaled by
// the Q9.16 registers scale_x and scale_y, truncated and saturated at 65535; a key that
// never appeared gives seen 0 and an all-zero rectangle. Throughput is one pixel per
// clock. The boxes pass from the snapshot buffer through the multiplier stage into the
// output register, and back-pressure on o_box stalls them; a frame-end pixel that
// arrives while the previous frame's boxes still occupy the snapshot buffer is held off
// (ready low) until they have left it, while ordinary pixels keep flowing. Registers
// are written through the APB port and should only be changed while the block is idle.

module color_key_bounding_boxes_top #(
    parameter int MAX_DIM = ckbb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ckbb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ckbb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ckbb_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    ckbb_pixel_if.sink                      i_pixel,
    ckbb_box_if.source                      o_box
);

    // Coordinate, span and product widths all follow from MAX_DIM.
    localparam int CW = $clog2(MAX_DIM);
    localparam int SW = CW + 1;
    localparam int PW = SW + ckbb_pkg::SCALE_W;
    localparam int EW = (PW > 33) ? PW : 33;
    localparam int DW = (SW > ckbb_pkg::DIM_W) ? SW : ckbb_pkg::DIM_W;
    localparam int NK = ckbb_pkg::NUM_KEYS;
    localparam int KW = ckbb_pkg::KEY_W;
    localparam int OW = ckbb_pkg::OUT_W;
    localparam logic [CW-1:0] MAX_COORD = CW'(MAX_DIM - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ckbb_pkg::DIM_W-1:0]   r_img_w;
    logic [ckbb_pkg::DIM_W-1:0]   r_img_h;
    logic [ckbb_pkg::SCALE_W-1:0] r_scale_x;
    logic [ckbb_pkg::SCALE_W-1:0] r_scale_y;
    logic [1:0]                   reg_idx;
    logic                         cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= ckbb_pkg::IMAGE_WIDTH_RST;
            r_img_h   <= ckbb_pkg::IMAGE_HEIGHT_RST;
            r_scale_x <= ckbb_pkg::SCALE_RST;
            r_scale_y <= ckbb_pkg::SCALE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ckbb_pkg::REG_IMAGE_WIDTH:  r_img_w   <= pwdata[ckbb_pkg::DIM_W-1:0];
                ckbb_pkg::REG_IMAGE_HEIGHT: r_img_h   <= pwdata[ckbb_pkg::DIM_W-1:0];
                ckbb_pkg::REG_SCALE_X:      r_scale_x <= pwdata[ckbb_pkg::SCALE_W-1:0];
                ckbb_pkg::REG_SCALE_Y:      r_scale_y <= pwdata[ckbb_pkg::SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ckbb_pkg::REG_IMAGE_WIDTH:  prdata = ckbb_pkg::APB_DATA_W'(r_img_w);
            ckbb_pkg::REG_IMAGE_HEIGHT: prdata = ckbb_pkg::APB_DATA_W'(r_img_h);
            ckbb_pkg::REG_SCALE_X:      prdata = ckbb_pkg::APB_DATA_W'(r_scale_x);
            ckbb_pkg::REG_SCALE_Y:      prdata = ckbb_pkg::APB_DATA_W'(r_scale_y);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel side: classification, counters and per-key tracking
    // ------------------------------------------------------------------
    logic          r_snap_full;
    logic          pix_acc;
    logic          pix_end;
    ckbb_pkg::t_class cls;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic          row_done;
    logic          frame_wrap;

    logic          r_seen [NK];
    logic [CW-1:0] r_lx   [NK];
    logic [CW-1:0] r_ly   [NK];
    logic [CW-1:0] r_mx   [NK];
    logic [CW-1:0] r_my   [NK];
    logic          n_seen [NK];
    logic [CW-1:0] n_lx   [NK];
    logic [CW-1:0] n_ly   [NK];
    logic [CW-1:0] n_mx   [NK];
    logic [CW-1:0] n_my   [NK];

    // Only a frame-end pixel has to wait for the snapshot buffer.
    assign i_pixel.ready = !(r_snap_full && i_pixel.frame_end);
    assign pix_acc       = i_pixel.valid && i_pixel.ready;
    assign pix_end       = pix_acc && i_pixel.frame_end;
    assign cls           = ckbb_pkg::classify(i_pixel.red, i_pixel.green, i_pixel.blue);

    // A width or height of zero behaves as one, since the compare is already true.
    assign row_done   = ((DW'(r_col) + DW'(1)) >= DW'(r_img_w)) || (r_col == MAX_COORD);
    assign frame_wrap = ((DW'(r_row) + DW'(1)) >= DW'(r_img_h)) || (r_row == MAX_COORD);

    always_comb begin
        n_col = row_done ? '0 : r_col + CW'(1);
        n_row = r_row;
        if (row_done) begin
            n_row = frame_wrap ? '0 : r_row + CW'(1);
        end
        for (int k = 0; k < NK; k++) begin
            n_seen[k] = r_seen[k];
            n_lx[k]   = r_lx[k];
            n_ly[k]   = r_ly[k];
            n_mx[k]   = r_mx[k];
            n_my[k]   = r_my[k];
            if (cls.hit && (cls.key == KW'(k))) begin
                n_seen[k] = 1'b1;
                if (r_col < r_lx[k]) n_lx[k] = r_col;
                if (r_row < r_ly[k]) n_ly[k] = r_row;
                if (r_col > r_mx[k]) n_mx[k] = r_col;
                if (r_row > r_my[k]) n_my[k] = r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || pix_end) begin
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < NK; k++) begin
                r_seen[k] <= 1'b0;
                r_lx[k]   <= MAX_COORD;
                r_ly[k]   <= MAX_COORD;
                r_mx[k]   <= '0;
                r_my[k]   <= '0;
            end
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            for (int k = 0; k < NK; k++) begin
                r_seen[k] <= n_seen[k];
                r_lx[k]   <= n_lx[k];
                r_ly[k]   <= n_ly[k];
                r_mx[k]   <= n_mx[k];
                r_my[k]   <= n_my[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot buffer: the closed frame's records, including its last pixel
    // ------------------------------------------------------------------
    logic          s_seen [NK];
    logic [CW-1:0] s_lx   [NK];
    logic [CW-1:0] s_ly   [NK];
    logic [CW-1:0] s_mx   [NK];
    logic [CW-1:0] s_my   [NK];
    logic [KW-1:0] r_emit_idx;

    always_ff @(posedge i_clk) begin
        if (pix_end) begin
            for (int k = 0; k < NK; k++) begin
                s_seen[k] <= n_seen[k];
                s_lx[k]   <= n_lx[k];
                s_ly[k]   <= n_ly[k];
                s_mx[k]   <= n_mx[k];
                s_my[k]   <= n_my[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Box side: multiplier stage, then saturation into the output register
    // ------------------------------------------------------------------
    logic          adv_b;
    logic          adv_a;
    logic          load_a;

    logic          r_a_valid;
    logic [KW-1:0] r_a_key;
    logic          r_a_seen;
    logic          r_a_last;
    logic [PW-1:0] r_a_px;
    logic [PW-1:0] r_a_py;
    logic [PW-1:0] r_a_pw;
    logic [PW-1:0] r_a_ph;

    logic [SW-1:0] span_x;
    logic [SW-1:0] span_y;

    logic          r_o_valid;
    logic [KW-1:0] r_o_key;
    logic          r_o_seen;
    logic          r_o_last;
    logic [OW-1:0] r_o_x;
    logic [OW-1:0] r_o_y;
    logic [OW-1:0] r_o_w;
    logic [OW-1:0] r_o_h;

    assign adv_b  = !r_o_valid || o_box.ready;
    assign adv_a  = !r_a_valid || adv_b;
    assign load_a = r_snap_full && adv_a;

    assign span_x = SW'(s_mx[r_emit_idx]) - SW'(s_lx[r_emit_idx]) + SW'(1);
    assign span_y = SW'(s_my[r_emit_idx]) - SW'(s_ly[r_emit_idx]) + SW'(1);

    // Product is Q22.16 at default MAX_DIM; keep [31:16] unless a bit above 31 is set.
    function automatic logic [OW-1:0] sat_scaled(input logic [PW-1:0] p);
        logic [EW-1:0] e;
        e = EW'(p);
        if (|e[EW-1:32]) begin
            return {OW{1'b1}};
        end
        return e[31:16];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_full <= 1'b0;
            r_emit_idx  <= '0;
            r_a_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (pix_end) begin
                r_snap_full <= 1'b1;
            end
            if (load_a) begin
                if (r_emit_idx == KW'(NK - 1)) begin
                    r_emit_idx  <= '0;
                    r_snap_full <= 1'b0;
                end else begin
                    r_emit_idx <= r_emit_idx + KW'(1);
                end
            end
            if (adv_a) begin
                r_a_valid <= r_snap_full;
            end
            if (adv_b) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_key  <= r_emit_idx;
            r_a_seen <= s_seen[r_emit_idx];
            r_a_last <= (r_emit_idx == ckbb_pkg::KEY_PURPLE);
            r_a_px   <= PW'(s_lx[r_emit_idx]) * PW'(r_scale_x);
            r_a_py   <= PW'(s_ly[r_emit_idx]) * PW'(r_scale_y);
            r_a_pw   <= PW'(span_x) * PW'(r_scale_x);
            r_a_ph   <= PW'(span_y) * PW'(r_scale_y);
        end
        if (adv_b && r_a_valid) begin
            r_o_key  <= r_a_key;
            r_o_seen <= r_a_seen;
            r_o_last <= r_a_last;
            r_o_x    <= r_a_seen ? sat_scaled(r_a_px) : '0;
            r_o_y    <= r_a_seen ? sat_scaled(r_a_py) : '0;
            r_o_w    <= r_a_seen ? sat_scaled(r_a_pw) : '0;
            r_o_h    <= r_a_seen ? sat_scaled(r_a_ph) : '0;
        end
    end

    assign o_box.valid      = r_o_valid;
    assign o_box.key_index  = r_o_key;
    assign o_box.seen       = r_o_seen;
    assign o_box.box_x      = r_o_x;
    assign o_box.box_y      = r_o_y;
    assign o_box.box_width  = r_o_w;
    assign o_box.box_height = r_o_h;
    assign o_box.last_key   = r_o_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_end_fills_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_end |=> r_snap_full)
        else $error("frame end did not fill the snapshot buffer");

    a_end_clears_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_end |=> (r_col == '0) && (r_row == '0) && !r_seen[0] && !r_seen[1]
                    && !r_seen[2] && !r_seen[3])
        else $error("tracking not cleared after frame end");

    a_emit_needs_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_idx != '0) |-> r_snap_full)
        else $error("emission index advanced without a snapshot");

    a_snapshot_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_snap_full) |-> $past(pix_end))
        else $error("snapshot buffer filled without a frame end");

endmodule
